>>> rtl/rcps_pkg.sv
// Shared types, codes and helpers for the RGB command parser with stopwatch.
package rcps_pkg;

    localparam logic [1:0] MODE_BYTE   = 2'd0;
    localparam logic [1:0] MODE_TICK   = 2'd1;
    localparam logic [1:0] MODE_BUTTON = 2'd2;

    localparam logic [1:0] KIND_COMPARE = 2'd0;
    localparam logic [1:0] KIND_ECHO    = 2'd1;
    localparam logic [1:0] KIND_TIME    = 2'd2;

    localparam logic [1:0] CH_NONE  = 2'd0;
    localparam logic [1:0] CH_RED   = 2'd1;
    localparam logic [1:0] CH_GREEN = 2'd2;
    localparam logic [1:0] CH_BLUE  = 2'd3;

    localparam logic [1:0] REG_TICKS_PER_SECOND = 2'd0;
    localparam logic [1:0] REG_DEBOUNCE_TICKS   = 2'd1;

    localparam logic [2:0] MAX_DIGITS = 3'd3;

    localparam logic [31:0] TICKS_PER_SECOND_RST = 32'd12000000;
    localparam logic [31:0] DEBOUNCE_TICKS_RST   = 32'd60000;

    localparam logic [7:0] ASCII_R     = 8'h72;
    localparam logic [7:0] ASCII_G     = 8'h67;
    localparam logic [7:0] ASCII_B     = 8'h62;
    localparam logic [7:0] ASCII_S     = 8'h73;
    localparam logic [7:0] ASCII_BANG  = 8'h21;
    localparam logic [7:0] ASCII_P     = 8'h70;
    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_NINE  = 8'd57;

    localparam logic [9:0] LEVEL_MID = 10'd255;

    typedef struct packed {
        logic        has;
        logic [1:0]  kind;
        logic [1:0]  channel;
        logic [9:0]  compare_value;
        logic [9:0]  level;
        logic [7:0]  echo_byte;
        logic [31:0] seconds;
        logic        running_flag;
    } t_result;

    function automatic logic [9:0] f_compare(input logic [9:0] lvl);
        logic [9:0] diff;
        if (lvl >= LEVEL_MID) begin
            diff = lvl - LEVEL_MID;
        end else begin
            diff = LEVEL_MID - lvl;
        end
        return diff;
    endfunction

endpackage

>>> rtl/rcps_parser.sv
// Command byte parser: channel select, digit accumulation, compare and echo items.
module rcps_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_byte,
    output rcps_pkg::t_result    o_res
);

    logic [1:0]  r_channel, n_channel;
    logic [1:0]  r_count,   n_count;
    logic [9:0]  r_accum,   n_accum;

    logic [13:0] sum;
    logic [9:0]  acc_next;
    logic [2:0]  count_inc;
    logic        is_letter;
    logic        is_digit;

    always_comb begin
        sum       = {4'd0, r_accum} * 14'd10 + {6'd0, i_byte - rcps_pkg::ASCII_ZERO};
        acc_next  = sum[9:0];
        count_inc = {1'b0, r_count} + 3'd1;
        is_letter = (i_byte == rcps_pkg::ASCII_R) || (i_byte == rcps_pkg::ASCII_G) ||
                    (i_byte == rcps_pkg::ASCII_B);
        is_digit  = (i_byte >= rcps_pkg::ASCII_ZERO) && (i_byte <= rcps_pkg::ASCII_NINE);

        n_channel = r_channel;
        n_count   = r_count;
        n_accum   = r_accum;
        o_res     = '0;

        if (is_letter) begin
            if (r_count != 2'd0 && r_channel != rcps_pkg::CH_NONE) begin
                o_res.has           = 1'b1;
                o_res.kind          = rcps_pkg::KIND_COMPARE;
                o_res.channel       = r_channel;
                o_res.level         = r_accum;
                o_res.compare_value = rcps_pkg::f_compare(r_accum);
            end
            n_count = 2'd0;
            n_accum = 10'd0;
            if (i_byte == rcps_pkg::ASCII_R) begin
                n_channel = rcps_pkg::CH_RED;
            end else if (i_byte == rcps_pkg::ASCII_G) begin
                n_channel = rcps_pkg::CH_GREEN;
            end else begin
                n_channel = rcps_pkg::CH_BLUE;
            end
        end else if (i_byte == rcps_pkg::ASCII_S || i_byte == rcps_pkg::ASCII_BANG ||
                     i_byte == rcps_pkg::ASCII_P) begin
            // stopwatch commands leave the parse state alone
        end else if (is_digit) begin
            if (r_channel == rcps_pkg::CH_NONE) begin
                o_res.has       = 1'b1;
                o_res.kind      = rcps_pkg::KIND_ECHO;
                o_res.echo_byte = i_byte;
            end else if (count_inc >= rcps_pkg::MAX_DIGITS) begin
                o_res.has           = 1'b1;
                o_res.kind          = rcps_pkg::KIND_COMPARE;
                o_res.channel       = r_channel;
                o_res.level         = acc_next;
                o_res.compare_value = rcps_pkg::f_compare(acc_next);
                n_channel           = rcps_pkg::CH_NONE;
                n_count             = 2'd0;
                n_accum             = 10'd0;
            end else begin
                n_count = count_inc[1:0];
                n_accum = acc_next;
            end
        end else begin
            o_res.has       = 1'b1;
            o_res.kind      = rcps_pkg::KIND_ECHO;
            o_res.echo_byte = i_byte;
            n_channel       = rcps_pkg::CH_NONE;
            n_count         = 2'd0;
            n_accum         = 10'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel <= rcps_pkg::CH_NONE;
            r_count   <= 2'd0;
            r_accum   <= 10'd0;
        end else if (i_step) begin
            r_channel <= n_channel;
            r_count   <= n_count;
            r_accum   <= n_accum;
        end
    end

endmodule

>>> rtl/rcps_watch.sv
// Stopwatch, button lockout and configuration registers.
module rcps_watch (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_wdata,
    input  logic                 i_step,
    input  logic [1:0]           i_mode,
    input  logic [7:0]           i_byte,
    output rcps_pkg::t_result    o_res
);

    logic [31:0] r_tps;
    logic [31:0] r_deb;
    logic        r_running, n_running;
    logic [31:0] r_seconds, n_seconds;
    logic [31:0] r_presc,   n_presc;
    logic [31:0] r_lock,    n_lock;

    logic [32:0] presc_inc;

    always_comb begin
        presc_inc = {1'b0, r_presc} + 33'd1;
        n_running = r_running;
        n_seconds = r_seconds;
        n_presc   = r_presc;
        n_lock    = r_lock;
        o_res     = '0;

        case (i_mode)
            rcps_pkg::MODE_BYTE: begin
                if (i_byte == rcps_pkg::ASCII_S) begin
                    n_running = !r_running;
                end else if (i_byte == rcps_pkg::ASCII_BANG) begin
                    n_running = 1'b0;
                    n_seconds = 32'd0;
                    n_presc   = 32'd0;
                end else if (i_byte == rcps_pkg::ASCII_P) begin
                    o_res.has = 1'b1;
                end
            end
            rcps_pkg::MODE_TICK: begin
                if (r_lock != 32'd0) begin
                    n_lock = r_lock - 32'd1;
                end
                if (r_running) begin
                    if (presc_inc >= {1'b0, r_tps}) begin
                        n_presc   = 32'd0;
                        n_seconds = r_seconds + 32'd1;
                    end else begin
                        n_presc = presc_inc[31:0];
                    end
                end
            end
            rcps_pkg::MODE_BUTTON: begin
                if (r_lock == 32'd0) begin
                    n_lock    = r_deb;
                    o_res.has = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (o_res.has) begin
            o_res.kind         = rcps_pkg::KIND_TIME;
            o_res.seconds      = r_seconds;
            o_res.running_flag = r_running;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps <= rcps_pkg::TICKS_PER_SECOND_RST;
            r_deb <= rcps_pkg::DEBOUNCE_TICKS_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == rcps_pkg::REG_TICKS_PER_SECOND) begin
                r_tps <= i_cfg_wdata;
            end else if (i_cfg_index == rcps_pkg::REG_DEBOUNCE_TICKS) begin
                r_deb <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 1'b1;
            r_seconds <= 32'd0;
            r_presc   <= 32'd0;
            r_lock    <= 32'd0;
        end else if (i_step) begin
            r_running <= n_running;
            r_seconds <= n_seconds;
            r_presc   <= n_presc;
            r_lock    <= n_lock;
        end
    end

endmodule

>>> rtl/rgb_command_parser_stopwatch.sv
// Top level: input register, parser and stopwatch, result register.
//
//   channel | direction | handshake               | payload
//   in      | input     | i_in_valid / o_in_stall  | i_in_mode, i_in_rx_byte
//   out     | output    | o_out_valid / i_out_stall| kind, channel, compare_value, level,
//           |           |                          | echo_byte, seconds, running_flag
//   cfg     | input     | i_cfg_we                 | i_cfg_index, i_cfg_wdata
//
// One item per cycle while the input is not stalled; an accepted item is held in
// the input register, then its result in the result register. Items without a
// result (ticks, s, !) keep flowing while the result register is stalled; an item
// with a result waits in the input register until the result register frees up.
// Synchronous active-low reset restores state and register defaults, but not payloads.
module rgb_command_parser_stopwatch (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_in_mode,
    input  logic [7:0]  i_in_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_out_kind,
    output logic [1:0]  o_out_channel,
    output logic [9:0]  o_out_compare_value,
    output logic [9:0]  o_out_level,
    output logic [7:0]  o_out_echo_byte,
    output logic [31:0] o_out_seconds,
    output logic        o_out_running_flag,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_wdata
);

    logic               r_in_valid;
    logic [1:0]         r_mode;
    logic [7:0]         r_byte;
    logic               r_out_valid;
    rcps_pkg::t_result  r_out;

    rcps_pkg::t_result  parse_res;
    rcps_pkg::t_result  watch_res;
    rcps_pkg::t_result  res;
    logic               out_free;
    logic               advance;
    logic               step;
    logic               byte_step;

    assign out_free  = !r_out_valid || !i_out_stall;
    assign advance   = !r_in_valid || out_free || !res.has;
    assign step      = r_in_valid && advance;
    assign byte_step = step && (r_mode == rcps_pkg::MODE_BYTE);
    assign o_in_stall = !advance;

    rcps_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (byte_step),
        .i_byte  (r_byte),
        .o_res   (parse_res)
    );

    rcps_watch u_watch (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (step),
        .i_mode      (r_mode),
        .i_byte      (r_byte),
        .o_res       (watch_res)
    );

    always_comb begin
        res = '0;
        if (r_mode == rcps_pkg::MODE_BYTE && parse_res.has) begin
            res = parse_res;
        end else if (watch_res.has) begin
            res = watch_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (advance) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_in_valid) begin
            r_mode <= i_in_mode;
            r_byte <= i_in_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid && res.has;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_in_valid && res.has) begin
            r_out <= res;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_out_kind          = r_out.kind;
    assign o_out_channel       = r_out.channel;
    assign o_out_compare_value = r_out.compare_value;
    assign o_out_level         = r_out.level;
    assign o_out_echo_byte     = r_out.echo_byte;
    assign o_out_seconds       = r_out.seconds;
    assign o_out_running_flag  = r_out.running_flag;

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled while result register could drain");

    a_compare_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_kind == rcps_pkg::KIND_COMPARE)
            |-> (o_out_channel != rcps_pkg::CH_NONE))
        else $error("compare item without a channel");

    a_compare_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_kind == rcps_pkg::KIND_COMPARE)
            |-> ((o_out_level >= rcps_pkg::LEVEL_MID)
                 ? (o_out_compare_value == o_out_level - rcps_pkg::LEVEL_MID)
                 : (o_out_compare_value == rcps_pkg::LEVEL_MID - o_out_level)))
        else $error("compare value does not match level");

    a_result_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_in_valid))
        else $error("result appeared without an item");

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the RGB command parser with stopwatch.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rcps_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int RESET_CYCLES    = 8;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_LIMIT     = 1000;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int N_PHASES        = 8;
    localparam int PHASE_ITEMS     = 192;
    localparam t_result NO_RESULT  = '0;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] rx;
        logic       pinned;
        t_result    exp;
    } t_cmd_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_in_mode = MODE_TICK;
    logic [7:0]  i_in_rx_byte = 8'h00;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_out_kind;
    logic [1:0]  o_out_channel;
    logic [9:0]  o_out_compare_value;
    logic [9:0]  o_out_level;
    logic [7:0]  o_out_echo_byte;
    logic [31:0] o_out_seconds;
    logic        o_out_running_flag;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = REG_TICKS_PER_SECOND;
    logic [31:0] i_cfg_wdata = '0;

    rgb_command_parser_stopwatch u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_in_mode           (i_in_mode),
        .i_in_rx_byte        (i_in_rx_byte),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_out_kind          (o_out_kind),
        .o_out_channel       (o_out_channel),
        .o_out_compare_value (o_out_compare_value),
        .o_out_level         (o_out_level),
        .o_out_echo_byte     (o_out_echo_byte),
        .o_out_seconds       (o_out_seconds),
        .o_out_running_flag  (o_out_running_flag),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_wdata         (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // parser and stopwatch shadow state
    logic [1:0]  pc_chan;
    logic [1:0]  pc_digits;
    logic [9:0]  pc_accum;
    logic        sw_running;
    logic [31:0] sw_seconds;
    logic [31:0] sw_prescale;
    logic [31:0] btn_lockout;
    logic [31:0] cf_tps;
    logic [31:0] cf_deb;

    t_result  pending_replies[$];
    t_cmd_row cmd_table[$];
    int       mismatch_count = 0;
    int       sent_count = 0;
    int       idle_cycles = 0;
    int       stall_hold = 0;
    bit       calm = 1'b0;

    function automatic t_result mk_compare(logic [1:0] ch, logic [9:0] lvl, logic [9:0] cmp);
        t_result r;
        r = '0;
        r.has = 1'b1;
        r.kind = KIND_COMPARE;
        r.channel = ch;
        r.compare_value = cmp;
        r.level = lvl;
        return r;
    endfunction

    function automatic t_result mk_echo(logic [7:0] b);
        t_result r;
        r = '0;
        r.has = 1'b1;
        r.kind = KIND_ECHO;
        r.echo_byte = b;
        return r;
    endfunction

    function automatic t_result mk_time(logic [31:0] s, logic run);
        t_result r;
        r = '0;
        r.has = 1'b1;
        r.kind = KIND_TIME;
        r.seconds = s;
        r.running_flag = run;
        return r;
    endfunction

    function automatic logic [7:0] dig(int n);
        return 8'(ASCII_ZERO + n);
    endfunction

    function automatic void clear_number();
        pc_digits = '0;
        pc_accum = '0;
    endfunction

    function automatic t_result level_reply();
        logic [9:0] cmp;
        cmp = (pc_accum >= LEVEL_MID) ? pc_accum - LEVEL_MID : LEVEL_MID - pc_accum;
        return mk_compare(pc_chan, pc_accum, cmp);
    endfunction

    // Advances the shadow state by one item; returns 1 when a reply is due.
    function automatic bit predict_reply(input logic [1:0] mode, input logic [7:0] rx,
                                         output t_result r);
        r = '0;
        case (mode)
            MODE_BYTE: begin
                if (rx == ASCII_R || rx == ASCII_G || rx == ASCII_B) begin
                    if (pc_digits != 0 && pc_chan != CH_NONE) begin
                        r = level_reply();
                    end
                    clear_number();
                    pc_chan = (rx == ASCII_R) ? CH_RED : (rx == ASCII_G) ? CH_GREEN : CH_BLUE;
                end else if (rx == ASCII_S) begin
                    sw_running = !sw_running;
                end else if (rx == ASCII_BANG) begin
                    sw_running = 1'b0;
                    sw_seconds = '0;
                    sw_prescale = '0;
                end else if (rx == ASCII_P) begin
                    r = mk_time(sw_seconds, sw_running);
                end else if (rx >= ASCII_ZERO && rx <= ASCII_NINE) begin
                    if (pc_chan == CH_NONE) begin
                        r = mk_echo(rx);
                    end else begin
                        pc_digits++;
                        pc_accum = 10'(pc_accum * 10 + (rx - ASCII_ZERO));
                        if (pc_digits >= MAX_DIGITS) begin
                            r = level_reply();
                            pc_chan = CH_NONE;
                            clear_number();
                        end
                    end
                end else begin
                    pc_chan = CH_NONE;
                    clear_number();
                    r = mk_echo(rx);
                end
            end
            MODE_TICK: begin
                if (btn_lockout != 0) begin
                    btn_lockout--;
                end
                if (sw_running) begin
                    if (sw_prescale == '1 || sw_prescale + 32'd1 >= cf_tps) begin
                        sw_prescale = '0;
                        sw_seconds++;
                    end else begin
                        sw_prescale++;
                    end
                end
            end
            MODE_BUTTON: begin
                if (btn_lockout == 0) begin
                    btn_lockout = cf_deb;
                    r = mk_time(sw_seconds, sw_running);
                end
            end
            default: ;
        endcase
        return r.has;
    endfunction

    function automatic int gap_len();
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end
        if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 30);
    endfunction

    task automatic report(input string msg);
        mismatch_count++;
        $display("%0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
        end
    endtask

    task automatic send_item(input logic [1:0] mode, input logic [7:0] rx,
                             input bit pinned, input t_result pin_val);
        int gap;
        bit has;
        t_result r;
        gap = gap_len();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_mode <= mode;
        i_in_rx_byte <= rx;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        has = predict_reply(mode, rx, r);
        if (pinned) begin
            if (pin_val.has) begin
                pending_replies.push_back(pin_val);
            end
        end else if (has) begin
            pending_replies.push_back(r);
        end
        if (mode != MODE_UNUSED) begin
            sent_count++;
        end
    endtask

    task automatic send_rand(input logic [1:0] mode, input logic [7:0] rx);
        send_item(mode, rx, 1'b0, NO_RESULT);
    endtask

    task automatic wait_results();
        i_in_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input logic [31:0] tps, input logic [31:0] deb);
        i_cfg_we <= 1'b1;
        i_cfg_index <= REG_TICKS_PER_SECOND;
        i_cfg_wdata <= tps;
        @(posedge i_clk);
        i_cfg_index <= REG_DEBOUNCE_TICKS;
        i_cfg_wdata <= deb;
        @(posedge i_clk);
        // index past the register list must be ignored
        i_cfg_index <= 2'(REG_DEBOUNCE_TICKS + $urandom_range(1, 2));
        i_cfg_wdata <= $urandom();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cf_tps = tps;
        cf_deb = deb;
    endtask

    function automatic logic [7:0] pick_letter();
        case ($urandom_range(0, 2))
            0: return ASCII_R;
            1: return ASCII_G;
            default: return ASCII_B;
        endcase
    endfunction

    function automatic logic [7:0] pick_watch_cmd();
        case ($urandom_range(0, 2))
            0: return ASCII_S;
            1: return ASCII_P;
            default: return ASCII_BANG;
        endcase
    endfunction

    task automatic run_phase(input int n);
        int target;
        int sel;
        int cnt;
        target = sent_count + n;
        while (sent_count < target) begin
            sel = $urandom_range(0, 99);
            if (sel < 35) begin
                send_rand(MODE_BYTE, pick_letter());
                cnt = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3);
                repeat (cnt) begin
                    if ($urandom_range(0, 9) == 0) begin
                        send_rand(MODE_BYTE, pick_watch_cmd());
                    end
                    send_rand(MODE_BYTE, dig($urandom_range(0, 9)));
                end
            end else if (sel < 60) begin
                repeat ($urandom_range(1, 20)) send_rand(MODE_TICK, 8'($urandom()));
            end else if (sel < 70) begin
                send_rand(MODE_BYTE, ASCII_P);
            end else if (sel < 75) begin
                send_rand(MODE_BYTE, ASCII_S);
            end else if (sel < 78) begin
                send_rand(MODE_BYTE, ASCII_BANG);
            end else if (sel < 88) begin
                send_rand(MODE_BUTTON, 8'($urandom()));
            end else if (sel < 96) begin
                send_rand(MODE_BYTE, 8'($urandom()));
            end else begin
                send_rand(MODE_UNUSED, 8'($urandom()));
            end
            if ($urandom_range(0, 199) == 0) begin
                wait_results();
            end
        end
    endtask

    initial begin
        int drain;
        pc_chan = CH_NONE;
        clear_number();
        sw_running = 1'b1;
        sw_seconds = '0;
        sw_prescale = '0;
        btn_lockout = '0;
        cf_tps = TICKS_PER_SECOND_RST;
        cf_deb = DEBOUNCE_TICKS_RST;

        cmd_table = '{
            '{MODE_BYTE,   dig(5),     1'b1, mk_echo(dig(5))},
            '{MODE_BYTE,   8'h00,      1'b1, mk_echo(8'h00)},
            '{MODE_BYTE,   ASCII_R,    1'b1, NO_RESULT},
            '{MODE_BYTE,   dig(9),     1'b0, NO_RESULT},
            '{MODE_BYTE,   dig(9),     1'b0, NO_RESULT},
            '{MODE_BYTE,   dig(9),     1'b1, mk_compare(CH_RED, 10'd999, 10'd744)},
            '{MODE_BYTE,   ASCII_G,    1'b0, NO_RESULT},
            '{MODE_BYTE,   dig(0),     1'b0, NO_RESULT},
            '{MODE_BYTE,   ASCII_B,    1'b1, mk_compare(CH_GREEN, 10'd0, 10'd255)},
            '{MODE_BYTE,   dig(2),     1'b0, NO_RESULT},
            '{MODE_BYTE,   dig(5),     1'b0, NO_RESULT},
            '{MODE_BYTE,   dig(5),     1'b1, mk_compare(CH_BLUE, 10'd255, 10'd0)},
            '{MODE_BYTE,   ASCII_R,    1'b0, NO_RESULT},
            '{MODE_BYTE,   dig(1),     1'b0, NO_RESULT},
            '{MODE_BYTE,   ASCII_S,    1'b0, NO_RESULT},
            '{MODE_BYTE,   ASCII_G,    1'b1, mk_compare(CH_RED, 10'd1, 10'd254)},
            '{MODE_BYTE,   dig(7),     1'b0, NO_RESULT},
            '{MODE_BYTE,   8'hFF,      1'b1, mk_echo(8'hFF)},
            '{MODE_BYTE,   dig(3),     1'b1, mk_echo(dig(3))},
            '{MODE_BUTTON, 8'h00,      1'b1, mk_time(32'd0, 1'b0)},
            '{MODE_BUTTON, 8'hFF,      1'b1, NO_RESULT},
            '{MODE_BYTE,   ASCII_S,    1'b0, NO_RESULT},
            '{MODE_TICK,   8'hFF,      1'b0, NO_RESULT},
            '{MODE_TICK,   8'h00,      1'b0, NO_RESULT},
            '{MODE_BUTTON, 8'h00,      1'b1, mk_time(32'd1, 1'b1)},
            '{MODE_BYTE,   ASCII_BANG, 1'b0, NO_RESULT},
            '{MODE_BYTE,   ASCII_P,    1'b1, mk_time(32'd0, 1'b0)}
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // short second and debounce so the directed rows can show both
        configure(32'd2, 32'd2);
        foreach (cmd_table[k]) begin
            send_item(cmd_table[k].mode, cmd_table[k].rx, cmd_table[k].pinned,
                      cmd_table[k].exp);
        end
        wait_results();

        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0: configure(32'd1, 32'd0);
                1: configure(32'd0, 32'd1);
                2: configure(32'd50, 32'd6);
                3: configure(32'd3, 32'd4);
                4: configure($urandom_range(1, 20), $urandom_range(0, 15));
                5: configure(32'd7, 32'd2);
                6: configure($urandom_range(1, 40), $urandom_range(1, 10));
                default: configure('1, '1);
            endcase
            calm = (p == 4);
            run_phase(PHASE_ITEMS);
            if (p != N_PHASES - 1) begin
                wait_results();
            end
        end

        i_in_valid <= 1'b0;
        drain = 0;
        while (pending_replies.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_replies.size() != 0) begin
            report($sformatf("%0d expected results never arrived", pending_replies.size()));
        end
        if (mismatch_count == 0) begin
            $display("rgb_command_parser_stopwatch regression: pass");
        end else begin
            $display("rgb_command_parser_stopwatch regression: fail");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (pending_replies.size() == 0) begin
                report($sformatf("unexpected result, kind 0x%0h", o_out_kind));
            end else begin
                want = pending_replies.pop_front();
                check_field("kind", o_out_kind, want.kind);
                check_field("channel", o_out_channel, want.channel);
                check_field("compare_value", o_out_compare_value, want.compare_value);
                check_field("level", o_out_level, want.level);
                check_field("echo_byte", o_out_echo_byte, want.echo_byte);
                check_field("seconds", o_out_seconds, want.seconds);
                check_field("running_flag", o_out_running_flag, want.running_flag);
            end
        end
        if (stall_hold == 0) begin
            stall_hold = gap_len();
        end
        if (stall_hold != 0) begin
            i_out_stall <= 1'b1;
            stall_hold--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) ||
            (i_rst_n && o_out_valid === 1'b1 && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("rgb_command_parser_stopwatch regression: fail");
            $finish;
        end
    end

endmodule
